/* sv/okvl_pkg.sv */
package okvl_pkg;

    localparam int DEF_CAPACITY = 16;
    localparam int TOTAL_W      = 5;
    localparam int KEY_W        = 32;
    localparam int DATA_W       = 32;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_SEARCH = 2'd2,
        CMD_CLEAR  = 2'd3
    } okvl_cmd_t;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } okvl_status_t;

    typedef struct packed {
        okvl_cmd_t                 command;
        logic signed [KEY_W-1:0]   key;
        logic        [DATA_W-1:0]  value;
    } okvl_req_t;

    typedef struct packed {
        okvl_status_t              status;
        logic signed [KEY_W-1:0]   found_key;
        logic        [DATA_W-1:0]  found_value;
        logic        [TOTAL_W-1:0] entry_total;
    } okvl_rsp_t;

    typedef struct packed {
        logic signed [KEY_W-1:0]  key;
        logic        [DATA_W-1:0] data;
    } okvl_entry_t;

    // Broadcast from the top level to every cell in the row.
    typedef struct packed {
        logic                     insert;
        logic                     delete_hit;
        logic                     clear;
        logic signed [KEY_W-1:0]  key;
        logic        [DATA_W-1:0] value;
    } okvl_cell_ctl_t;

endpackage

/* sv/okvl_cell.sv */
module okvl_cell (
    input  logic                    clk,
    input  logic                    rst_n,
    input  okvl_pkg::okvl_cell_ctl_t ctl,
    input  logic                    prev_used,
    input  logic                    next_used,
    input  okvl_pkg::okvl_entry_t   next_entry,
    input  logic                    match_in,
    output logic                    match_out,
    input  okvl_pkg::okvl_entry_t   found_in,
    output okvl_pkg::okvl_entry_t   found_out,
    output logic                    used,
    output okvl_pkg::okvl_entry_t   entry
);
    import okvl_pkg::*;

    logic        used_reg;
    logic        used_next;
    okvl_entry_t entry_reg;
    okvl_entry_t entry_next;
    logic        hit_here;
    logic        is_tail;
    logic        shift_in;

    assign hit_here  = used_reg && (entry_reg.key == ctl.key) && !match_in;
    assign match_out = match_in || hit_here;
    assign found_out = hit_here ? entry_reg : found_in;

    // The first free slot sits right after the last used one.
    assign is_tail  = !used_reg && prev_used;
    // On a delete every cell at or after the hit takes its neighbor's contents.
    assign shift_in = ctl.delete_hit && match_out;

    always_comb
    begin
        used_next  = used_reg;
        entry_next = entry_reg;
        priority if (ctl.clear)
        begin
            used_next = 1'b0;
        end
        else if (ctl.insert && is_tail)
        begin
            used_next       = 1'b1;
            entry_next.key  = ctl.key;
            entry_next.data = ctl.value;
        end
        else if (shift_in)
        begin
            used_next  = next_used;
            entry_next = next_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= 1'b0;
        end
        else
        begin
            used_reg <= used_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign used  = used_reg;
    assign entry = entry_reg;

endmodule

/* sv/ordered_key_value_list.sv */
// Channel   Ports                 Handshake
// request   start, busy, request  taken when start is high and busy is low
// result    done, result          one-cycle strobe, cannot be held off
//
// Every request is accepted when it is offered and its result appears with done in
// the next cycle, so a new request may follow every cycle; busy stays low.
// The row of cells compares all keys at once and a first-match chain through
// the cells picks the oldest hit; a delete shifts the later cells down.
// Reset empties the store (count zero, all cells unused).
module ordered_key_value_list #(
    parameter int CAPACITY = okvl_pkg::DEF_CAPACITY
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  okvl_pkg::okvl_req_t request,
    output logic                done,
    output okvl_pkg::okvl_rsp_t result
);
    import okvl_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              done_reg;
    okvl_rsp_t         result_reg;
    okvl_rsp_t         result_next;
    logic              accept;
    logic              full;
    logic              any_match;
    logic              do_insert;
    logic              do_delete;
    logic              do_search;
    logic              do_clear;
    logic [CNT_W+TOTAL_W-1:0] total_ext;
    okvl_cell_ctl_t    ctl;

    logic        [CAPACITY:0] used_chain;
    logic        [CAPACITY:0] match_chain;
    logic        [CAPACITY-1:0] used_vec;
    okvl_entry_t [CAPACITY:0] found_chain;
    okvl_entry_t [CAPACITY:0] entry_chain;

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign full   = (count_reg == CNT_W'(CAPACITY));

    assign do_insert = accept && (request.command == CMD_INSERT) && !full;
    assign do_delete = accept && (request.command == CMD_DELETE) && any_match;
    assign do_search = accept && (request.command == CMD_SEARCH);
    assign do_clear  = accept && (request.command == CMD_CLEAR);

    assign ctl.insert     = do_insert;
    assign ctl.delete_hit = do_delete;
    assign ctl.clear      = do_clear;
    assign ctl.key        = request.key;
    assign ctl.value      = request.value;

    assign used_chain[0]         = 1'b1;
    assign match_chain[0]        = 1'b0;
    assign found_chain[0]        = '0;
    assign used_vec[CAPACITY-1]  = used_chain[CAPACITY];
    assign entry_chain[CAPACITY] = '0;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic next_used;
            if (gi == CAPACITY - 1)
            begin : g_last
                assign next_used = 1'b0;
            end
            else
            begin : g_mid
                assign next_used = used_vec[gi+1];
                assign used_vec[gi] = used_chain[gi+1];
            end

            okvl_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctl        (ctl),
                .prev_used  (used_chain[gi]),
                .next_used  (next_used),
                .next_entry (entry_chain[gi+1]),
                .match_in   (match_chain[gi]),
                .match_out  (match_chain[gi+1]),
                .found_in   (found_chain[gi]),
                .found_out  (found_chain[gi+1]),
                .used       (used_chain[gi+1]),
                .entry      (entry_chain[gi])
            );
        end
    endgenerate

    assign any_match = match_chain[CAPACITY];

    always_comb
    begin
        count_next = count_reg;
        if (do_clear)
        begin
            count_next = '0;
        end
        else if (do_insert)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_delete)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    assign total_ext = {{TOTAL_W{1'b0}}, count_next};

    always_comb
    begin
        result_next             = '0;
        result_next.status      = ST_DONE;
        result_next.entry_total = total_ext[TOTAL_W-1:0];
        unique case (request.command)
            CMD_INSERT:
            begin
                if (full)
                begin
                    result_next.status = ST_FULL;
                end
            end
            CMD_DELETE, CMD_SEARCH:
            begin
                if (any_match)
                begin
                    result_next.found_key   = found_chain[CAPACITY].key;
                    result_next.found_value = found_chain[CAPACITY].data;
                end
                else
                begin
                    result_next.status = ST_NOT_FOUND;
                end
            end
            CMD_CLEAR:
            begin
                result_next.status = ST_DONE;
            end
            default:
            begin
                result_next.status = ST_DONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    // The used cells stay packed at the head; this check compares their number with the count.
    a_count_matches_cells: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(used_vec) == int'(count_reg))
        else $error("cell occupancy disagrees with entry count");

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        do_clear |=> (count_reg == '0) && (used_vec == '0))
        else $error("clear left entries behind");

    a_search_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
        do_search |=> $stable(count_reg))
        else $error("search changed the entry count");

    a_found_implies_match: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (request.command == CMD_DELETE) && !any_match) |=>
        (result.status == ST_NOT_FOUND) && $stable(count_reg))
        else $error("delete without a match changed the store");

endmodule

/* sim/ordered_key_value_list_tb.sv */
`timescale 1ns / 1ps

module ordered_key_value_list_tb;
    import okvl_pkg::*;

    localparam int RANDOM_ITEMS = 550;
    localparam int QUIET_TAIL   = 100;
    localparam int CYCLE_LIMIT  = 200000;
    localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
    localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;

    typedef struct {
        okvl_req_t req;
        bit        typed;
        okvl_rsp_t rsp;
    } stim_row_t;

    logic      clk;
    logic      rst_n;
    logic      start;
    logic      busy;
    okvl_req_t request;
    logic      done;
    okvl_rsp_t result;

    // Expectation typed into the current directed row, seen by the checker.
    bit        row_typed;
    okvl_rsp_t row_expected;

    // Shadow copy of the store, kept packed oldest first.
    logic signed [KEY_W-1:0] shadow_key [DEF_CAPACITY];
    logic [DATA_W-1:0]       shadow_data [DEF_CAPACITY];
    int                      shadow_count = 0;

    okvl_rsp_t expected_results[$];
    stim_row_t directed_rows[$];
    int        mismatch_count = 0;
    int        cycle_count = 0;

    ordered_key_value_list uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic okvl_rsp_t shadow_step(input okvl_req_t req);
        okvl_rsp_t rsp;
        int        hit;
        rsp = '0;
        rsp.status = ST_DONE;
        hit = -1;
        case (req.command)
            CMD_INSERT:
            begin
                if (shadow_count >= DEF_CAPACITY)
                    rsp.status = ST_FULL;
                else
                begin
                    shadow_key[shadow_count] = req.key;
                    shadow_data[shadow_count] = req.value;
                    shadow_count++;
                end
            end
            CMD_DELETE, CMD_SEARCH:
            begin
                for (int i = 0; i < shadow_count; i++)
                    if (hit < 0 && shadow_key[i] == req.key)
                        hit = i;
                if (hit < 0)
                    rsp.status = ST_NOT_FOUND;
                else
                begin
                    rsp.found_key = shadow_key[hit];
                    rsp.found_value = shadow_data[hit];
                    if (req.command == CMD_DELETE)
                    begin
                        // Later entries close the gap left by the removed one.
                        for (int i = hit; i < shadow_count - 1; i++)
                        begin
                            shadow_key[i] = shadow_key[i + 1];
                            shadow_data[i] = shadow_data[i + 1];
                        end
                        shadow_count--;
                    end
                end
            end
            default:
                shadow_count = 0;
        endcase
        rsp.entry_total = TOTAL_W'(shadow_count);
        return rsp;
    endfunction

    // Acceptance and result checking share one process so that a request taken
    // at an edge is queued before any result at that edge is matched.
    always @(posedge clk)
    begin
        okvl_rsp_t want;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                want = shadow_step(request);
                if (row_typed)
                    want = row_expected;
                expected_results.push_back(want);
            end
            if (done)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result with no request outstanding");
                    mismatch_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (result.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, result.status);
                        mismatch_count++;
                    end
                    if (result.found_key !== want.found_key)
                    begin
                        $error("found_key: expected %h, got %h",
                               want.found_key, result.found_key);
                        mismatch_count++;
                    end
                    if (result.found_value !== want.found_value)
                    begin
                        $error("found_value: expected %h, got %h",
                               want.found_value, result.found_value);
                        mismatch_count++;
                    end
                    if (result.entry_total !== want.entry_total)
                    begin
                        $error("entry_total: expected %0d, got %0d",
                               want.entry_total, result.entry_total);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    function automatic void add_row(input okvl_cmd_t cmd, input logic signed [KEY_W-1:0] key,
                                    input logic [DATA_W-1:0] value, input bit typed,
                                    input okvl_status_t status,
                                    input logic signed [KEY_W-1:0] fkey,
                                    input logic [DATA_W-1:0] fvalue, input int total);
        stim_row_t row;
        row.req.command = cmd;
        row.req.key = key;
        row.req.value = value;
        row.typed = typed;
        row.rsp.status = status;
        row.rsp.found_key = fkey;
        row.rsp.found_value = fvalue;
        row.rsp.entry_total = TOTAL_W'(total);
        directed_rows.push_back(row);
    endfunction

    // Most keys come from a small pool so that deletes and searches hit often.
    function automatic logic signed [KEY_W-1:0] pick_key();
        if ($urandom_range(0, 3) == 0)
            return $urandom;
        case ($urandom_range(0, 7))
            0: return KEY_MIN;
            1: return KEY_MAX;
            2: return 0;
            3: return -1;
            4: return 1;
            5: return 42;
            6: return -42;
            default: return 1000;
        endcase
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_request(input okvl_req_t req, input bit typed, input okvl_rsp_t rsp,
                                input int gap);
        if (gap > 0)
        begin
            start = 1'b0;
            repeat (gap) @(negedge clk);
        end
        request = req;
        row_typed = typed;
        row_expected = rsp;
        start = 1'b1;
        do
            @(posedge clk);
        while (busy);
        @(negedge clk);
    endtask

    initial
    begin
        okvl_req_t req;
        okvl_rsp_t none;
        int        insert_pct;
        int        pick;
        int        gap;

        none = '0;
        rst_n = 1'b0;
        start = 1'b0;
        request = '0;
        row_typed = 1'b0;
        row_expected = '0;

        add_row(CMD_SEARCH, 0, 0, 1, ST_NOT_FOUND, 0, 0, 0);
        add_row(CMD_DELETE, KEY_MIN, 0, 1, ST_NOT_FOUND, 0, 0, 0);
        add_row(CMD_INSERT, KEY_MIN, 32'h0000_0000, 1, ST_DONE, 0, 0, 1);
        add_row(CMD_INSERT, KEY_MAX, 32'hFFFF_FFFF, 1, ST_DONE, 0, 0, 2);
        add_row(CMD_INSERT, KEY_MAX, 32'h0000_0001, 1, ST_DONE, 0, 0, 3);
        // With a duplicate key the oldest entry wins.
        add_row(CMD_SEARCH, KEY_MAX, 0, 1, ST_DONE, KEY_MAX, 32'hFFFF_FFFF, 3);
        add_row(CMD_DELETE, KEY_MAX, 0, 1, ST_DONE, KEY_MAX, 32'hFFFF_FFFF, 2);
        add_row(CMD_SEARCH, KEY_MAX, 0, 1, ST_DONE, KEY_MAX, 32'h0000_0001, 2);
        add_row(CMD_DELETE, KEY_MIN, 0, 1, ST_DONE, KEY_MIN, 32'h0000_0000, 1);
        for (int i = 0; i < DEF_CAPACITY - 1; i++)
            add_row(CMD_INSERT, 3 * i - 7, $urandom, 0, ST_DONE, 0, 0, 0);
        add_row(CMD_INSERT, -5, 32'h7FC0_0000, 1, ST_FULL, 0, 0, DEF_CAPACITY);
        add_row(CMD_CLEAR, KEY_MAX, 32'hFFFF_FFFF, 1, ST_DONE, 0, 0, 0);

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
        begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 11) : 0;
            send_request(directed_rows[i].req, directed_rows[i].typed,
                         directed_rows[i].rsp, gap);
        end

        insert_pct = 50;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            // Swing between filling and draining so both ends of the store are reached.
            if (n % 40 == 0)
                insert_pct = $urandom_range(20, 75);
            if (n == RANDOM_ITEMS / 2)
            begin
                start = 1'b0;
                while (expected_results.size() != 0)
                    @(negedge clk);
            end
            pick = $urandom_range(0, 99);
            if (pick < 2)
                req.command = CMD_CLEAR;
            else if (pick < 2 + insert_pct)
                req.command = CMD_INSERT;
            else if ($urandom_range(0, 1) == 0)
                req.command = CMD_DELETE;
            else
                req.command = CMD_SEARCH;
            req.key = pick_key();
            req.value = $urandom;
            gap = 0;
            if (n < RANDOM_ITEMS - QUIET_TAIL && $urandom_range(0, 4) == 0)
                gap = $urandom_range(1, 11);
            send_request(req, 1'b0, none, gap);
        end

        start = 1'b0;
        while (expected_results.size() != 0)
            @(negedge clk);
        repeat (5) @(negedge clk);

        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
